// ----- hdl/assert_macros.svh -----
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/prao_pkg.sv -----
package prao_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  // rotated offsets stay far inside this width
  localparam int ROT_W   = 36;
  localparam int SC_W    = 32;
  localparam int K_W     = 7;

  localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
  localparam logic [31:0] Q30_HALF = 32'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam int ROUND_HALF = 536870912;

  localparam int COS_TERMS = 5;
  localparam int SIN_TERMS = 4;
  // sideband delays inside the sine/cosine unit
  localparam int SB_LEN  = 18;
  localparam int R_LEN   = 13;
  localparam int SIN_LEN = 3;
  // registered stages ahead of the rotation cells, and through the last rotation cell
  localparam int SC_LAT     = 19;
  localparam int PIPE_DEPTH = 25;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef enum logic [1:0] {
    PLANE_XY = 2'd0,
    PLANE_XZ = 2'd1,
    PLANE_YZ = 2'd2
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] pivot_z;
    logic [ANGLE_W-1:0]        angle_xy;
    logic [ANGLE_W-1:0]        angle_xz;
    logic [ANGLE_W-1:0]        angle_yz;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;
    logic                      overflow;
  } out_req_t;

  typedef struct packed {
    logic signed [ROT_W-1:0]   x;
    logic signed [ROT_W-1:0]   y;
    logic signed [ROT_W-1:0]   z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] pivot_z;
    logic signed [SC_W-1:0]    sn_xy;
    logic signed [SC_W-1:0]    cs_xy;
    logic signed [SC_W-1:0]    sn_xz;
    logic signed [SC_W-1:0]    cs_xz;
    logic signed [SC_W-1:0]    sn_yz;
    logic signed [SC_W-1:0]    cs_yz;
  } rot_pkt_t;

  // horner divisors and floor(2^32 / k) reciprocals
  function automatic logic [K_W-1:0] cos_div_k(input int idx);
    case (idx)
      0: return 7'd90;
      1: return 7'd56;
      2: return 7'd30;
      3: return 7'd12;
      default: return 7'd2;
    endcase
  endfunction

  function automatic logic [31:0] cos_div_m(input int idx);
    case (idx)
      0: return 32'd47721858;
      1: return 32'd76695844;
      2: return 32'd143165576;
      3: return 32'd357913941;
      default: return 32'd2147483648;
    endcase
  endfunction

  function automatic logic [K_W-1:0] sin_div_k(input int idx);
    case (idx)
      0: return 7'd72;
      1: return 7'd42;
      2: return 7'd20;
      default: return 7'd6;
    endcase
  endfunction

  function automatic logic [31:0] sin_div_m(input int idx);
    case (idx)
      0: return 32'd59652323;
      1: return 32'd102261126;
      2: return 32'd214748364;
      default: return 32'd715827882;
    endcase
  endfunction

endpackage

// ----- hdl/prao_horner_cell.sv -----
// one horner step: t_out = 1 - floor(floor(x2 * t) / k), three stages
module prao_horner_cell import prao_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [K_W-1:0] div_k,
  input  logic [31:0]    div_m,
  input  logic [29:0]    x2_in,
  input  logic [30:0]    t_in,
  output logic [29:0]    x2_out,
  output logic [30:0]    t_out
);

  logic [59:0] prod_a;
  logic [29:0] v_a_r;
  logic [29:0] x2_a_r;
  logic [61:0] prod_b;
  logic [29:0] q0_b_r;
  logic [29:0] v_b_r;
  logic [29:0] x2_b_r;
  logic [37:0] qk;
  logic [37:0] rem;
  logic [29:0] q_c;
  logic [30:0] t_nxt;
  logic [30:0] t_r;
  logic [29:0] x2_c_r;

  assign prod_a = 60'(x2_in) * 60'(t_in);
  assign prod_b = 62'(v_a_r) * 62'(div_m);

  // reciprocal estimate is low by at most one
  assign qk    = 38'(q0_b_r) * 38'(div_k);
  assign rem   = 38'(v_b_r) - qk;
  assign q_c   = (rem >= 38'(div_k)) ? q0_b_r + 30'd1 : q0_b_r;
  assign t_nxt = 31'(Q30_ONE) - {1'b0, q_c};

  always_ff @(posedge clk) begin
    if (en) begin
      v_a_r  <= prod_a[59:30];
      x2_a_r <= x2_in;
      q0_b_r <= prod_b[61:32];
      v_b_r  <= v_a_r;
      x2_b_r <= x2_a_r;
      t_r    <= t_nxt;
      x2_c_r <= x2_b_r;
    end
  end

  assign t_out  = t_r;
  assign x2_out = x2_c_r;

endmodule

// ----- hdl/prao_sincos.sv -----
// binary angle to q2.30 sine and cosine, SC_LAT stages
module prao_sincos import prao_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_W-1:0]     angle,
  output logic signed [SC_W-1:0] sin_q30,
  output logic signed [SC_W-1:0] cos_q30
);

  logic [31:0] phase;
  logic [29:0] frac;
  logic        swap_nxt;
  logic [30:0] fold;
  logic [29:0] g_nxt;
  logic [29:0] g_r;
  quad_t       quad_d_r [SB_LEN];
  logic        swap_d_r [SB_LEN];
  logic [62:0] r_prod;
  logic [29:0] r_r;
  logic [59:0] x2_prod;
  logic [29:0] x2_r;
  logic [29:0] r_d_r [R_LEN];
  logic [29:0] cos_x2 [COS_TERMS+1];
  logic [30:0] cos_t  [COS_TERMS+1];
  logic [29:0] sin_x2 [SIN_TERMS+1];
  logic [30:0] sin_t  [SIN_TERMS+1];
  logic [59:0] sin_prod;
  logic [29:0] sin_d_r [SIN_LEN];
  logic signed [SC_W-1:0] s0;
  logic signed [SC_W-1:0] c0;
  logic signed [SC_W-1:0] sin_nxt;
  logic signed [SC_W-1:0] cos_nxt;
  logic signed [SC_W-1:0] sin_r;
  logic signed [SC_W-1:0] cos_r;

  // fold into the first octant
  assign phase    = 32'(angle) << (32 - ANGLE_W);
  assign frac     = phase[29:0];
  assign swap_nxt = frac > 30'(Q30_HALF);
  assign fold     = 31'(Q30_ONE) - {1'b0, frac};
  assign g_nxt    = swap_nxt ? fold[29:0] : frac;

  assign r_prod  = 63'(g_r) * 63'(PI_Q30) + 63'(Q30_ONE);
  assign x2_prod = 60'(r_r) * 60'(r_r);

  always_ff @(posedge clk) begin
    if (en) begin
      g_r         <= g_nxt;
      quad_d_r[0] <= quad_t'(phase[31:30]);
      swap_d_r[0] <= swap_nxt;
      for (int i = 1; i < SB_LEN; i++) begin
        quad_d_r[i] <= quad_d_r[i-1];
        swap_d_r[i] <= swap_d_r[i-1];
      end
      r_r      <= r_prod[60:31];
      x2_r     <= x2_prod[59:30];
      r_d_r[0] <= r_r;
      for (int i = 1; i < R_LEN; i++) begin
        r_d_r[i] <= r_d_r[i-1];
      end
      sin_d_r[0] <= sin_prod[59:30];
      for (int i = 1; i < SIN_LEN; i++) begin
        sin_d_r[i] <= sin_d_r[i-1];
      end
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign cos_x2[0] = x2_r;
  assign cos_t[0]  = 31'(Q30_ONE);
  assign sin_x2[0] = x2_r;
  assign sin_t[0]  = 31'(Q30_ONE);

  for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
    prao_horner_cell u_cell (
      .clk    (clk),
      .en     (en),
      .div_k  (cos_div_k(i)),
      .div_m  (cos_div_m(i)),
      .x2_in  (cos_x2[i]),
      .t_in   (cos_t[i]),
      .x2_out (cos_x2[i+1]),
      .t_out  (cos_t[i+1])
    );
  end

  for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
    prao_horner_cell u_cell (
      .clk    (clk),
      .en     (en),
      .div_k  (sin_div_k(i)),
      .div_m  (sin_div_m(i)),
      .x2_in  (sin_x2[i]),
      .t_in   (sin_t[i]),
      .x2_out (sin_x2[i+1]),
      .t_out  (sin_t[i+1])
    );
  end

  assign sin_prod = 60'(r_d_r[R_LEN-1]) * 60'(sin_t[SIN_TERMS]);

  // undo octant fold, then quadrant signs
  always_comb begin
    if (swap_d_r[SB_LEN-1]) begin
      s0 = {1'b0, cos_t[COS_TERMS]};
      c0 = {2'b00, sin_d_r[SIN_LEN-1]};
    end else begin
      s0 = {2'b00, sin_d_r[SIN_LEN-1]};
      c0 = {1'b0, cos_t[COS_TERMS]};
    end
    case (quad_d_r[SB_LEN-1])
      QUAD_0: begin
        sin_nxt = s0;
        cos_nxt = c0;
      end
      QUAD_1: begin
        sin_nxt = c0;
        cos_nxt = -s0;
      end
      QUAD_2: begin
        sin_nxt = -s0;
        cos_nxt = -c0;
      end
      default: begin
        sin_nxt = -c0;
        cos_nxt = s0;
      end
    endcase
  end

  assign sin_q30 = sin_r;
  assign cos_q30 = cos_r;

endmodule

// ----- hdl/prao_rot_cell.sv -----
// one plane rotation: a' = a*c - b*s, b' = a*s + b*c, round half up
module prao_rot_cell import prao_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  plane_t   plane,
  input  rot_pkt_t pkt_in,
  output rot_pkt_t pkt_out
);

  localparam int PROD_W = ROT_W + SC_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [ROT_W-1:0]  a;
  logic signed [ROT_W-1:0]  b;
  logic signed [SC_W-1:0]   sn;
  logic signed [SC_W-1:0]   cs;
  logic signed [PROD_W-1:0] pac_r;
  logic signed [PROD_W-1:0] pbs_r;
  logic signed [PROD_W-1:0] pas_r;
  logic signed [PROD_W-1:0] pbc_r;
  rot_pkt_t                 pkt_a_r;
  logic signed [SUM_W-1:0]  sum_a;
  logic signed [SUM_W-1:0]  sum_b;
  logic signed [ROT_W-1:0]  na;
  logic signed [ROT_W-1:0]  nb;
  rot_pkt_t                 pkt_nxt;
  rot_pkt_t                 pkt_r;

  always_comb begin
    case (plane)
      PLANE_XZ: begin
        a  = pkt_in.z;
        b  = pkt_in.x;
        sn = pkt_in.sn_xz;
        cs = pkt_in.cs_xz;
      end
      PLANE_YZ: begin
        a  = pkt_in.z;
        b  = pkt_in.y;
        sn = pkt_in.sn_yz;
        cs = pkt_in.cs_yz;
      end
      default: begin
        a  = pkt_in.x;
        b  = pkt_in.y;
        sn = pkt_in.sn_xy;
        cs = pkt_in.cs_xy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pac_r   <= PROD_W'(a) * PROD_W'(cs);
      pbs_r   <= PROD_W'(b) * PROD_W'(sn);
      pas_r   <= PROD_W'(a) * PROD_W'(sn);
      pbc_r   <= PROD_W'(b) * PROD_W'(cs);
      pkt_a_r <= pkt_in;
      pkt_r   <= pkt_nxt;
    end
  end

  assign sum_a = SUM_W'(pac_r) - SUM_W'(pbs_r) + SUM_W'(ROUND_HALF);
  assign sum_b = SUM_W'(pas_r) + SUM_W'(pbc_r) + SUM_W'(ROUND_HALF);
  assign na    = sum_a[ROT_W+29:30];
  assign nb    = sum_b[ROT_W+29:30];

  always_comb begin
    pkt_nxt = pkt_a_r;
    case (plane)
      PLANE_XZ: begin
        pkt_nxt.z = na;
        pkt_nxt.x = nb;
      end
      PLANE_YZ: begin
        pkt_nxt.z = na;
        pkt_nxt.y = nb;
      end
      default: begin
        pkt_nxt.x = na;
        pkt_nxt.y = nb;
      end
    endcase
  end

  assign pkt_out = pkt_r;

endmodule

// ----- hdl/point_rotate_about_origin_3d.sv -----
// Rotates a Q16.16 point about a pivot by three binary angles (XY, then XZ, then YZ
// plane) and returns the saturated result with an overflow flag. The block is a
// straight pipeline that takes one request per clock while in_stall is low; the
// accepting edge loads the first of 26 register stages: 19 stages of sine/cosine
// generation, whose horner chain of five three-stage cells sets that depth, six stages
// of rotation cells and the output register. When the output stalls, the pipeline
// keeps filling until a result reaches the last rotation stage behind the stalled
// result, and only then holds in_stall high.
`include "assert_macros.svh"

module point_rotate_about_origin_3d import prao_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  typedef struct packed {
    logic signed [COORD_W-1:0] val;
    logic                      ovf;
  } sat_t;

  // saturate a widened coordinate to the port width
  function automatic sat_t sat_coord(input logic signed [ROT_W:0] v);
    sat_t res;
    res.ovf = (v[ROT_W:COORD_W-1] != '0) && (v[ROT_W:COORD_W-1] != '1);
    if (!res.ovf) begin
      res.val = v[COORD_W-1:0];
    end else if (v[ROT_W]) begin
      res.val = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic                   en;
  logic [PIPE_DEPTH-1:0]  vld_r;
  rot_pkt_t               ofs_nxt;
  rot_pkt_t               dly_r [SC_LAT];
  logic signed [SC_W-1:0] sn_xy;
  logic signed [SC_W-1:0] cs_xy;
  logic signed [SC_W-1:0] sn_xz;
  logic signed [SC_W-1:0] cs_xz;
  logic signed [SC_W-1:0] sn_yz;
  logic signed [SC_W-1:0] cs_yz;
  rot_pkt_t               rot_pkt [4];
  sat_t                   sat_x;
  sat_t                   sat_y;
  sat_t                   sat_z;
  out_req_t               out_nxt;
  out_req_t               out_req_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   load_out;

  // everything moves unless a finished result would overwrite a stalled one
  assign en       = !(vld_r[PIPE_DEPTH-1] && out_valid_r && out_stall);
  assign in_stall = !en;
  assign load_out = en && vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // offsets from the pivot, carried alongside the sine/cosine units
  always_comb begin
    ofs_nxt         = '0;
    ofs_nxt.x       = ROT_W'(in_req.point_x) - ROT_W'(in_req.pivot_x);
    ofs_nxt.y       = ROT_W'(in_req.point_y) - ROT_W'(in_req.pivot_y);
    ofs_nxt.z       = ROT_W'(in_req.point_z) - ROT_W'(in_req.pivot_z);
    ofs_nxt.pivot_x = in_req.pivot_x;
    ofs_nxt.pivot_y = in_req.pivot_y;
    ofs_nxt.pivot_z = in_req.pivot_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= ofs_nxt;
      for (int i = 1; i < SC_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  prao_sincos u_sc_xy (
    .clk     (clk),
    .en      (en),
    .angle   (in_req.angle_xy),
    .sin_q30 (sn_xy),
    .cos_q30 (cs_xy)
  );

  prao_sincos u_sc_xz (
    .clk     (clk),
    .en      (en),
    .angle   (in_req.angle_xz),
    .sin_q30 (sn_xz),
    .cos_q30 (cs_xz)
  );

  prao_sincos u_sc_yz (
    .clk     (clk),
    .en      (en),
    .angle   (in_req.angle_yz),
    .sin_q30 (sn_yz),
    .cos_q30 (cs_yz)
  );

  // offsets meet their sines and cosines here
  always_comb begin
    rot_pkt[0]       = dly_r[SC_LAT-1];
    rot_pkt[0].sn_xy = sn_xy;
    rot_pkt[0].cs_xy = cs_xy;
    rot_pkt[0].sn_xz = sn_xz;
    rot_pkt[0].cs_xz = cs_xz;
    rot_pkt[0].sn_yz = sn_yz;
    rot_pkt[0].cs_yz = cs_yz;
  end

  // rotation cells, xy then xz then yz
  prao_rot_cell u_rot_xy (
    .clk     (clk),
    .en      (en),
    .plane   (PLANE_XY),
    .pkt_in  (rot_pkt[0]),
    .pkt_out (rot_pkt[1])
  );

  prao_rot_cell u_rot_xz (
    .clk     (clk),
    .en      (en),
    .plane   (PLANE_XZ),
    .pkt_in  (rot_pkt[1]),
    .pkt_out (rot_pkt[2])
  );

  prao_rot_cell u_rot_yz (
    .clk     (clk),
    .en      (en),
    .plane   (PLANE_YZ),
    .pkt_in  (rot_pkt[2]),
    .pkt_out (rot_pkt[3])
  );

  // pivot back on, then clamp
  assign sat_x = sat_coord((ROT_W+1)'(rot_pkt[3].x) + (ROT_W+1)'(rot_pkt[3].pivot_x));
  assign sat_y = sat_coord((ROT_W+1)'(rot_pkt[3].y) + (ROT_W+1)'(rot_pkt[3].pivot_y));
  assign sat_z = sat_coord((ROT_W+1)'(rot_pkt[3].z) + (ROT_W+1)'(rot_pkt[3].pivot_z));

  always_comb begin
    out_nxt.rotated_x = sat_x.val;
    out_nxt.rotated_y = sat_y.val;
    out_nxt.rotated_z = sat_z.val;
    out_nxt.overflow  = sat_x.ovf || sat_y.ovf || sat_z.ovf;
  end

  // output register: loads a new result, holds while stalled, clears when taken
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_req_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  `ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_req_r), "stalled result lost or changed")
  `ASSERT_NEXT(a_out_load, load_out, out_valid_r, "finished result not presented")
  `ASSERT_NEXT(a_in_enter, in_valid && !in_stall, vld_r[0], "accepted request not in pipeline")

endmodule

// ----- bench/point_rotate_about_origin_3d_tb.sv -----
`timescale 1ns / 100ps

module point_rotate_about_origin_3d_tb;
  import prao_pkg::*;

  typedef logic signed [127:0] wide_t;

  // rotation scoreboard: predicts each accepted request and checks results in order
  class rotate_scoreboard;
    out_req_t pending[$];
    int errors;
    int checked;
    int saturated;

    function longint unsigned sin_series(longint unsigned x);
      longint unsigned x2, t;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
    endfunction

    function longint unsigned cos_series(longint unsigned x);
      longint unsigned x2, t;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 90;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 56;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
      return t;
    endfunction

    function void angle_trig(logic [ANGLE_W-1:0] ang, output wide_t sn, output wide_t cs);
      logic [31:0] phase;
      quad_t quad;
      longint unsigned f, g, r;
      wide_t s0, c0, tmp;
      phase = {ang, 16'h0000};
      quad = quad_t'(phase[31:30]);
      f = phase[29:0];
      g = (f > 64'd536870912) ? (64'd1 << 30) - f : f;
      r = (g * 64'd3373259426 + (64'd1 << 30)) >> 31;
      s0 = sin_series(r);
      c0 = cos_series(r);
      if (f > 64'd536870912) begin
        tmp = s0; s0 = c0; c0 = tmp;
      end
      case (quad)
        QUAD_0: begin sn = s0;  cs = c0;  end
        QUAD_1: begin sn = c0;  cs = -s0; end
        QUAD_2: begin sn = -s0; cs = -c0; end
        default: begin sn = -c0; cs = s0; end
      endcase
    endfunction

    // a*ca +/- b*cb in q30, rounded half up
    function wide_t blend(wide_t a, wide_t ca, wide_t b, wide_t cb, bit minus);
      wide_t acc;
      acc = minus ? a * ca - b * cb : a * ca + b * cb;
      acc = acc + 128'sd536870912;
      return acc >>> 30;
    endfunction

    function logic signed [31:0] clamp(wide_t v, inout logic ovf);
      if (v > 128'sd2147483647) begin
        ovf = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
        ovf = 1'b1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    function void note(in_req_t rq);
      wide_t x, y, z, nx, ny, nz, sn, cs;
      out_req_t res;
      logic ovf;
      ovf = 1'b0;
      x = wide_t'(rq.point_x) - wide_t'(rq.pivot_x);
      y = wide_t'(rq.point_y) - wide_t'(rq.pivot_y);
      z = wide_t'(rq.point_z) - wide_t'(rq.pivot_z);
      angle_trig(rq.angle_xy, sn, cs);
      nx = blend(x, cs, y, sn, 1'b1);
      ny = blend(x, sn, y, cs, 1'b0);
      x = nx; y = ny;
      angle_trig(rq.angle_xz, sn, cs);
      nx = blend(x, cs, z, sn, 1'b0);
      nz = blend(z, cs, x, sn, 1'b1);
      x = nx; z = nz;
      angle_trig(rq.angle_yz, sn, cs);
      ny = blend(y, cs, z, sn, 1'b0);
      nz = blend(z, cs, y, sn, 1'b1);
      y = ny; z = nz;
      res.rotated_x = clamp(x + wide_t'(rq.pivot_x), ovf);
      res.rotated_y = clamp(y + wide_t'(rq.pivot_y), ovf);
      res.rotated_z = clamp(z + wide_t'(rq.pivot_z), ovf);
      res.overflow = ovf;
      pending.push_back(res);
    endfunction

    function void check(out_req_t got);
      out_req_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h ovf=%b", $time,
                 got.rotated_x, got.rotated_y, got.rotated_z, got.overflow);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.overflow) saturated++;
      if (got.rotated_x !== exp_r.rotated_x) begin
        $display("%0t: rotated_x expected %h actual %h", $time, exp_r.rotated_x,
                 got.rotated_x);
        errors++;
      end
      if (got.rotated_y !== exp_r.rotated_y) begin
        $display("%0t: rotated_y expected %h actual %h", $time, exp_r.rotated_y,
                 got.rotated_y);
        errors++;
      end
      if (got.rotated_z !== exp_r.rotated_z) begin
        $display("%0t: rotated_z expected %h actual %h", $time, exp_r.rotated_z,
                 got.rotated_z);
        errors++;
      end
      if (got.overflow !== exp_r.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, exp_r.overflow,
                 got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  rotate_scoreboard sb = new();
  int cycle_count = 0;
  int sent = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_rotate_about_origin_3d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  // watchdog: far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // request and result monitors, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note(in_req);
    if (rst_n && out_valid && !out_stall) sb.check(out_req);
  end

  // receiver stall pattern: rotates between free-running, light, heavy and periodic
  always @(posedge clk) begin
    case ((cycle_count >> 9) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      2: out_stall <= ($urandom_range(3) != 0);
      default: out_stall <= (cycle_count % 7) < 3;
    endcase
  end

  // hold one request until the block takes it
  task automatic send_req(in_req_t rq);
    in_valid <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic in_req_t make_req(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                       logic [15:0] axy, logic [15:0] axz,
                                       logic [15:0] ayz);
    in_req_t r;
    r.point_x = px; r.point_y = py; r.point_z = pz;
    r.pivot_x = cx; r.pivot_y = cy; r.pivot_z = cz;
    r.angle_xy = axy; r.angle_xz = axz; r.angle_yz = ayz;
    return r;
  endfunction

  // mostly modest coordinates, sometimes full range so saturation shows up
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
      2: return $signed($urandom_range(32'h3fff_ffff)) - 32'sh2000_0000;
      default: return $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return {2'($urandom_range(3)), 14'h0000};
      1: return 16'(32'h2000 + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  in_req_t directed[$];

  initial begin
    int burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, quadrant edges, fold point and extreme angles
    directed.push_back(make_req(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0,
                                16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_req(32'h0001_0000, 0, 0, 0, 0, 0, 16'h4000, 16'h0000, 16'h0000));
    directed.push_back(make_req(32'h0001_0000, 0, 0, 0, 0, 0, 16'h8000, 16'h4000, 16'h0000));
    directed.push_back(make_req(0, 32'h0001_0000, 0, 0, 0, 0, 16'hc000, 16'h8000, 16'h4000));
    directed.push_back(make_req(0, 0, 32'h0001_0000, 0, 0, 0, 16'h2000, 16'hc000, 16'h8000));
    directed.push_back(make_req(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0,
                                16'h2001, 16'h1fff, 16'hc000));
    directed.push_back(make_req(32'h0005_0000, 32'hfffb_0000, 32'h0001_8000,
                                32'h0001_0000, 32'h0002_0000, 32'hffff_0000,
                                16'hffff, 16'hffff, 16'hffff));
    directed.push_back(make_req(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 0, 0, 0,
                                16'h0001, 16'h0001, 16'h0001));
    // wide offsets, point and pivot at opposite extremes, and extreme points that saturate
    directed.push_back(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                16'h8000, 16'h8000, 16'h8000));
    directed.push_back(make_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0,
                                16'h2000, 16'h2000, 16'h2000));
    directed.push_back(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                                16'h2000, 16'h6000, 16'ha000));
    directed.push_back(make_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                16'h1234, 16'hfedc, 16'h8001));
    directed.push_back(make_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                16'h5555, 16'haaaa, 16'h7fff));
    foreach (directed[i]) send_req(directed[i]);
    idle_gap(1);

    // let the pipe drain completely before the random traffic
    while (sb.pending.size() != 0) @(posedge clk);

    while (sent < 1614) begin
      burst = $urandom_range(40, 1);
      repeat (burst) begin
        send_req(make_req(pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), pick_coord(),
                          pick_angle(), pick_angle(), pick_angle()));
      end
      // some bursts run straight into the next one
      idle_gap(($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1));
    end
    idle_gap(1);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests (%0d directed), %0d results checked, %0d saturated",
             sent, directed.size(), sb.checked, sb.saturated);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
